/* sv/edwf_pkg.sv */
package edwf_pkg;

    localparam int MAX_QUERY_LEN   = 16;
    localparam int COUNT_WIDTH     = 8;
    localparam int NUM_CELLS       = MAX_QUERY_LEN + 1;
    localparam int QLEN_W          = $clog2(MAX_QUERY_LEN + 1);
    localparam int CHAR_W          = 8;
    localparam int QUERY_REG_CHARS = 16;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 3;
    localparam int QLEN_CFG_W      = 5;
    localparam int TARGET_W        = 8;
    localparam int MATCH_W         = 16;
    localparam int DIST_W          = 8;

    localparam logic [COUNT_WIDTH-1:0] CELL_MAX = '1;
    localparam logic [DIST_W-1:0]      DIST_MAX = '1;

    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_LOW   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_HIGH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_LEN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_DIST = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_MATCHES = 3'd4;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef struct packed {
        logic [CHAR_W-1:0] word_char;
        logic              is_last;
        logic              empty_word;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic               length_ok;
        logic               is_match;
        logic [MATCH_W-1:0] match_count;
    } t_out_item;

    // One character moving along the row of cells, with the values that the
    // next cell needs from its left neighbour.
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic              empty;
        logic [CHAR_W-1:0] wc;
        t_count            left;
        t_count            diag;
        t_count            tap_val;
        t_count            wlen;
    } t_tok;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic t_count sat_inc(input t_count v);
        t_count r;
        r = (v == CELL_MAX) ? CELL_MAX : v + t_count'(1);
        return r;
    endfunction

    function automatic t_count reset_val(input int k);
        t_count r;
        if (k > int'(CELL_MAX)) begin
            r = CELL_MAX;
        end else begin
            r = t_count'(k);
        end
        return r;
    endfunction

endpackage

/* sv/edwf_cell.sv */
module edwf_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  edwf_pkg::t_tok              i_tok,
    input  logic [edwf_pkg::CHAR_W-1:0] i_qchar,
    input  logic                        i_head,
    input  edwf_pkg::t_count            i_index,
    input  logic                        i_tap,
    output edwf_pkg::t_tok              o_tok
);

    edwf_pkg::t_count r_val;
    edwf_pkg::t_count n_val;
    edwf_pkg::t_tok   r_tok;
    edwf_pkg::t_tok   n_tok;

    edwf_pkg::t_count old_val;
    edwf_pkg::t_count via_up;
    edwf_pkg::t_count via_left;
    edwf_pkg::t_count via_diag;
    edwf_pkg::t_count best;
    edwf_pkg::t_count cur;
    logic             same_char;

    always_comb begin
        // The first character of a word sees the cleared row.
        old_val   = i_tok.first ? i_index : r_val;
        same_char = !i_head && (edwf_pkg::fold_case(i_qchar) == i_tok.wc);
        via_up    = edwf_pkg::sat_inc(old_val);
        via_left  = edwf_pkg::sat_inc(i_tok.left);
        via_diag  = same_char ? i_tok.diag : edwf_pkg::sat_inc(i_tok.diag);
        best      = via_up;
        if (via_left < best) begin
            best = via_left;
        end
        if (via_diag < best) begin
            best = via_diag;
        end
        cur = i_tok.empty ? old_val : best;

        n_tok      = i_tok;
        n_tok.left = best;
        n_tok.diag = old_val;
        if (i_tap) begin
            n_tok.tap_val = cur;
        end
        if (i_head) begin
            n_tok.wlen = cur;
        end

        n_val = r_val;
        if (i_tok.valid && !i_tok.empty) begin
            n_val = best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_val <= n_val;
        end
    end

    assign o_tok = r_tok;

endmodule

/* sv/edwf_result.sv */
module edwf_result (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  edwf_pkg::t_tok                   i_tok,
    input  logic [edwf_pkg::QLEN_W-1:0]      i_qlen,
    input  logic [edwf_pkg::TARGET_W-1:0]    i_target,
    input  logic [edwf_pkg::MATCH_W-1:0]     i_max_matches,
    input  logic                             i_out_ready,
    output logic                             o_adv,
    output logic                             o_out_valid,
    output edwf_pkg::t_out_item              o_out_item
);

    localparam int DIFF_W = (edwf_pkg::COUNT_WIDTH > edwf_pkg::QLEN_W) ?
                            edwf_pkg::COUNT_WIDTH : edwf_pkg::QLEN_W;
    localparam int CMP_W  = (DIFF_W > edwf_pkg::TARGET_W) ? DIFF_W : edwf_pkg::TARGET_W;

    logic                         r_valid;
    edwf_pkg::t_out_item          r_item;
    logic [edwf_pkg::MATCH_W-1:0] r_count;
    logic [edwf_pkg::MATCH_W-1:0] n_count;
    edwf_pkg::t_out_item          n_item;

    logic [DIFF_W-1:0]            wlen_x;
    logic [DIFF_W-1:0]            qlen_x;
    logic [DIFF_W-1:0]            diff;
    logic [edwf_pkg::DIST_W-1:0]  sat_dist;
    logic                         len_ok;
    logic                         match;
    logic                         ends;
    logic                         adv;

    assign adv  = !r_valid || i_out_ready;
    assign ends = i_tok.valid && i_tok.last;

    always_comb begin
        wlen_x = DIFF_W'(i_tok.wlen);
        qlen_x = DIFF_W'(i_qlen);
        diff   = (wlen_x >= qlen_x) ? wlen_x - qlen_x : qlen_x - wlen_x;
        if (i_tok.tap_val > edwf_pkg::COUNT_WIDTH'(edwf_pkg::DIST_MAX)) begin
            sat_dist = edwf_pkg::DIST_MAX;
        end else begin
            sat_dist = edwf_pkg::DIST_W'(i_tok.tap_val);
        end
        len_ok  = CMP_W'(diff) <= CMP_W'(i_target);
        match   = len_ok && (sat_dist == i_target) && (r_count < i_max_matches);
        n_count = match ? r_count + edwf_pkg::MATCH_W'(1) : r_count;

        n_item.distance    = sat_dist;
        n_item.length_ok   = len_ok;
        n_item.is_match    = match;
        n_item.match_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else if (adv) begin
            r_valid <= ends;
            if (ends) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && ends) begin
            r_item <= n_item;
        end
    end

    assign o_adv       = adv;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

/* sv/edit_distance_word_filter.sv */
// Case-insensitive Levenshtein filter. Dictionary words stream in one character per
// request, and a request with empty_word set ends a word without adding a character.
// A row of MAX_QUERY_LEN + 1 cells, one per column of the edit-distance table, passes
// each character one cell onward per cycle, so a new request is taken every cycle while
// the output register is free or being read. The result of a word passes through every
// cell, whatever the query length, and then the output register; a stall on the output
// side holds the whole row. The user must write configuration only while no word is in
// flight; the block itself does not enforce this.
module edit_distance_word_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  edwf_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output edwf_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_we,
    input  logic [edwf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [edwf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [edwf_pkg::CFG_DATA_W-1:0] r_query_low;
    logic [edwf_pkg::CFG_DATA_W-1:0] r_query_high;
    logic [edwf_pkg::QLEN_CFG_W-1:0] r_query_len;
    logic [edwf_pkg::TARGET_W-1:0]   r_target;
    logic [edwf_pkg::MATCH_W-1:0]    r_max_matches;
    logic                            r_first;

    logic [2*edwf_pkg::CFG_DATA_W-1:0] query_all;
    logic [edwf_pkg::QLEN_W-1:0]       qlen;
    logic                              adv;
    logic                              accept;
    logic                              ends;
    edwf_pkg::t_tok                    chain [edwf_pkg::NUM_CELLS+1];

    assign query_all = {r_query_high, r_query_low};
    assign o_in_ready = adv;
    assign accept     = i_in_valid && adv;
    assign ends       = i_in_item.empty_word || i_in_item.is_last;

    always_comb begin
        if (int'(r_query_len) > edwf_pkg::MAX_QUERY_LEN) begin
            qlen = edwf_pkg::QLEN_W'(edwf_pkg::MAX_QUERY_LEN);
        end else begin
            qlen = edwf_pkg::QLEN_W'(r_query_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_low   <= '0;
            r_query_high  <= '0;
            r_query_len   <= '0;
            r_target      <= '0;
            r_max_matches <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                edwf_pkg::REG_QUERY_LOW: begin
                    r_query_low <= i_cfg_data;
                end
                edwf_pkg::REG_QUERY_HIGH: begin
                    r_query_high <= i_cfg_data;
                end
                edwf_pkg::REG_QUERY_LEN: begin
                    r_query_len <= i_cfg_data[edwf_pkg::QLEN_CFG_W-1:0];
                end
                edwf_pkg::REG_TARGET_DIST: begin
                    r_target <= i_cfg_data[edwf_pkg::TARGET_W-1:0];
                end
                edwf_pkg::REG_MAX_MATCHES: begin
                    r_max_matches <= i_cfg_data[edwf_pkg::MATCH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The request after a finished word starts from a cleared row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (accept) begin
            r_first <= ends;
        end
    end

    always_comb begin
        chain[0].valid   = i_in_valid;
        chain[0].first   = r_first;
        chain[0].last    = ends;
        chain[0].empty   = i_in_item.empty_word;
        chain[0].wc      = edwf_pkg::fold_case(i_in_item.word_char);
        chain[0].left    = edwf_pkg::CELL_MAX;
        chain[0].diag    = edwf_pkg::CELL_MAX;
        chain[0].tap_val = '0;
        chain[0].wlen    = '0;
    end

    for (genvar k = 0; k < edwf_pkg::NUM_CELLS; k++) begin : g_cell
        logic [edwf_pkg::CHAR_W-1:0] qchar;
        logic                        tap;

        if (k >= 1 && k - 1 < edwf_pkg::QUERY_REG_CHARS) begin : g_qc
            assign qchar = query_all[edwf_pkg::CHAR_W*(k-1) +: edwf_pkg::CHAR_W];
        end else begin : g_nqc
            assign qchar = '0;
        end

        assign tap = (int'(qlen) == k);

        edwf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_tok   (chain[k]),
            .i_qchar (qchar),
            .i_head  (k == 0),
            .i_index (edwf_pkg::reset_val(k)),
            .i_tap   (tap),
            .o_tok   (chain[k+1])
        );
    end

    edwf_result u_result (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tok         (chain[edwf_pkg::NUM_CELLS]),
        .i_qlen        (qlen),
        .i_target      (r_target),
        .i_max_matches (r_max_matches),
        .i_out_ready   (i_out_ready),
        .o_adv         (adv),
        .o_out_valid   (o_out_valid),
        .o_out_item    (o_out_item)
    );

endmodule

/* tb/sv/edit_distance_word_filter_test.sv */
module edit_distance_word_filter_test;

    timeunit 1ns;
    timeprecision 1ps;

    import edwf_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = MAX_QUERY_LEN + 12;
    localparam int HOLD_CYCLES  = 300;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PATTERN} t_ready_mode;
    typedef enum int {EDIT_SUBST, EDIT_INSERT, EDIT_DELETE} t_edit;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   o_in_ready;
    t_in_item               in_item   = '0;
    logic                   o_out_valid;
    logic                   out_ready = 1'b0;
    t_out_item              o_out_item;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_QUERY_LOW;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predicted state of the filter.
    logic [63:0]        qry_low;
    logic [63:0]        qry_high;
    logic [4:0]         qry_len;
    logic [7:0]         tgt_dist;
    logic [15:0]        match_limit;
    t_count             dist_row [0:MAX_QUERY_LEN];
    t_count             word_len;
    logic [15:0]        match_total;
    t_out_item          expected_verdicts[$];

    logic [7:0]         word_buf[$];
    t_ready_mode        ready_mode  = READY_ALWAYS;
    int                 gap_max     = 0;
    int                 burst_left  = 0;
    bit                 hold_req    = 1'b0;
    int                 hold_left   = 0;
    int                 pat_cnt     = 0;
    int                 errors      = 0;
    int                 requests_sent = 0;
    int                 verdicts_seen = 0;
    int                 matches_seen  = 0;
    int                 cycle_count   = 0;

    edit_distance_word_filter u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic t_count bump(input t_count v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    function automatic logic [7:0] query_byte(input int pos);
        logic [7:0] r;
        r = 8'h00;
        if (pos < 8) begin
            r = qry_low[8*pos +: 8];
        end else if (pos < 16) begin
            r = qry_high[8*(pos-8) +: 8];
        end
        return r;
    endfunction

    function automatic int query_len_used();
        return (qry_len > MAX_QUERY_LEN) ? MAX_QUERY_LEN : int'(qry_len);
    endfunction

    function automatic void clear_row();
        int i;
        for (i = 0; i <= MAX_QUERY_LEN; i++) begin
            dist_row[i] = (i > int'(t_count'('1))) ? '1 : t_count'(i);
        end
        word_len = '0;
    endfunction

    function automatic void advance_distance_row(input logic [7:0] ch);
        t_count     diag;
        t_count     left;
        t_count     up;
        t_count     best;
        logic [7:0] wc;
        int         i;
        wc = to_lower(ch);
        diag = dist_row[0];
        left = bump(dist_row[0]);
        dist_row[0] = left;
        for (i = 1; i <= MAX_QUERY_LEN; i++) begin
            up = dist_row[i];
            best = bump(up);
            if (bump(left) < best) begin
                best = bump(left);
            end
            if (to_lower(query_byte(i - 1)) == wc) begin
                if (diag < best) begin
                    best = diag;
                end
            end else if (bump(diag) < best) begin
                best = bump(diag);
            end
            diag = up;
            dist_row[i] = best;
            left = best;
        end
        word_len = bump(word_len);
    endfunction

    function automatic void finish_word();
        t_out_item v;
        int        qlen;
        int        diff;
        qlen = query_len_used();
        v.distance = dist_row[qlen];
        diff = int'(word_len) - qlen;
        if (diff < 0) begin
            diff = -diff;
        end
        v.length_ok = (diff <= int'(tgt_dist));
        v.is_match = v.length_ok && (v.distance == tgt_dist) && (match_total < match_limit);
        if (v.is_match) begin
            match_total++;
            matches_seen++;
        end
        v.match_count = match_total;
        expected_verdicts.insert(expected_verdicts.size(), v);
        clear_row();
    endfunction

    function automatic void take_request(input t_in_item it);
        if (!it.empty_word) begin
            advance_distance_row(it.word_char);
            if (!it.is_last) begin
                return;
            end
        end
        finish_word();
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_QUERY_LOW:   qry_low     = data;
            REG_QUERY_HIGH:  qry_high    = data;
            REG_QUERY_LEN:   qry_len     = data[4:0];
            REG_TARGET_DIST: tgt_dist    = data[7:0];
            REG_MAX_MATCHES: match_limit = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_verdict(input t_out_item got);
        t_out_item want;
        if (expected_verdicts.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, got distance %0d match %0b",
                     $time, got.distance, got.is_match);
            errors++;
        end else begin
            want = expected_verdicts.pop_front();
            compare_field("distance", 16'(want.distance), 16'(got.distance));
            compare_field("length_ok", 16'(want.length_ok), 16'(got.length_ok));
            compare_field("is_match", 16'(want.is_match), 16'(got.is_match));
            compare_field("match_count", want.match_count, got.match_count);
        end
        verdicts_seen++;
    endfunction

    // Values are sampled just after the edge, before any nonblocking update lands.
    always @(posedge clk) begin
        if (rst_n && o_out_valid === 1'b1 && out_ready) begin
            check_verdict(o_out_item);
        end
    end

    always @(posedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        pat_cnt = (pat_cnt == 4) ? 0 : pat_cnt + 1;
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            case (ready_mode)
                READY_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
                READY_PATTERN: out_ready <= (pat_cnt >= 2);
                default:       out_ready <= 1'b1;
            endcase
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic t_in_item make_item(input logic [7:0] ch, input logic last,
                                           input logic empty);
        t_in_item it;
        it.word_char  = ch;
        it.is_last    = last;
        it.empty_word = empty;
        return it;
    endfunction

    function automatic logic [63:0] text_chunk(input string s, input int first);
        logic [63:0] v;
        int          k;
        v = '0;
        for (k = 0; k < 8; k++) begin
            if (first + k < s.len()) begin
                v[8*k +: 8] = s[first + k];
            end
        end
        return v;
    endfunction

    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        c = 8'h61 + 8'($urandom_range(0, 25));
        return ($urandom_range(0, 1) != 0) ? flip_case(c) : c;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
    endtask

    task automatic set_filter(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len, input logic [7:0] tgt,
                              input logic [15:0] lim);
        write_reg(REG_QUERY_LOW, lo);
        write_reg(REG_QUERY_HIGH, hi);
        write_reg(REG_QUERY_LEN, 64'(len));
        write_reg(REG_TARGET_DIST, 64'(tgt));
        write_reg(REG_MAX_MATCHES, 64'(lim));
        cfg_we <= 1'b0;
    endtask

    task automatic set_traffic(input int gaps, input t_ready_mode mode);
        gap_max    = gaps;
        burst_left = 0;
        ready_mode = mode;
    endtask

    task automatic send_request(input t_in_item it);
        if (gap_max != 0) begin
            if (burst_left == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (o_in_ready !== 1'b1);
        take_request(it);
        requests_sent++;
    endtask

    task automatic send_word_buf();
        int k;
        if (word_buf.size() == 0) begin
            send_request(make_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1));
        end else begin
            for (k = 0; k < word_buf.size(); k++) begin
                send_request(make_item(word_buf[k], k == word_buf.size() - 1, 1'b0));
            end
        end
    endtask

    task automatic send_text(input string s);
        int k;
        word_buf.delete();
        for (k = 0; k < s.len(); k++) begin
            word_buf.insert(word_buf.size(), s[k]);
        end
        send_word_buf();
    endtask

    // Random bytes, with the odd early word end mixed in.
    task automatic send_noise_word();
        int n;
        int k;
        n = $urandom_range(1, 20);
        for (k = 0; k < n; k++) begin
            send_request(make_item(8'($urandom_range(0, 255)),
                                   (k == n - 1) || ($urandom_range(0, 15) == 0),
                                   $urandom_range(0, 9) == 0));
        end
    endtask

    function automatic void mutate_query(input int edits);
        int    k;
        int    pos;
        t_edit kind;
        word_buf.delete();
        for (k = 0; k < query_len_used(); k++) begin
            word_buf.insert(word_buf.size(), query_byte(k));
        end
        for (k = 0; k < edits; k++) begin
            pos  = $urandom_range(0, word_buf.size());
            kind = t_edit'($urandom_range(0, 2));
            case (kind)
                EDIT_SUBST: begin
                    if (pos < word_buf.size()) word_buf[pos] = random_letter();
                end
                EDIT_INSERT: word_buf.insert(pos, random_letter());
                default: begin
                    if (pos < word_buf.size()) word_buf.delete(pos);
                end
            endcase
        end
        for (k = 0; k < word_buf.size(); k++) begin
            if ($urandom_range(0, 1) != 0) word_buf[k] = flip_case(word_buf[k]);
        end
    endfunction

    // The sender stops and waits for every outstanding result, then lets the row drain.
    task automatic wait_for_verdicts();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic randomise_filter();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        logic [7:0]  tgt;
        logic [15:0] lim;
        int          k;
        for (k = 0; k < 8; k++) begin
            lo[8*k +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                        : random_letter();
            hi[8*k +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                        : random_letter();
        end
        case ($urandom_range(0, 7))
            0:       len = 5'd0;
            1:       len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 9))
            0:       tgt = 8'd255;
            1:       tgt = 8'($urandom_range(4, 255));
            default: tgt = 8'($urandom_range(0, 3));
        endcase
        case ($urandom_range(0, 5))
            0:       lim = 16'd0;
            1:       lim = 16'hFFFF;
            default: lim = match_total + 16'($urandom_range(1, 20));
        endcase
        set_filter(lo, hi, len, tgt, lim);
    endtask

    task automatic reset_filter();
        qry_low     = '0;
        qry_high    = '0;
        qry_len     = '0;
        tgt_dist    = '0;
        match_limit = '0;
        match_total = '0;
        clear_row();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    endtask

    task automatic test_reset_state();
        set_traffic(0, READY_ALWAYS);
        send_text("");
        send_text("x");
        wait_for_verdicts();
    endtask

    // Only A-Z fold; the neighbouring punctuation must compare raw.
    task automatic test_case_folding();
        set_filter(text_chunk("AZ@[az`{", 0), 64'd0, 5'd8, 8'd0, 16'hFFFF);
        set_traffic(3, READY_RANDOM);
        send_text("az@[AZ`{");
        send_text("AZ`{az@[");
        wait_for_verdicts();
    endtask

    task automatic test_extreme_bytes();
        set_filter(64'h0000_0000_0080_00FF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd3, 8'd0, 16'hFFFF);
        set_traffic(0, READY_PATTERN);
        send_request(make_item(8'hFF, 1'b0, 1'b0));
        send_request(make_item(8'h00, 1'b0, 1'b0));
        send_request(make_item(8'h80, 1'b1, 1'b0));
        send_request(make_item(8'hFF, 1'b0, 1'b1));
        wait_for_verdicts();
    endtask

    task automatic test_query_length_limits();
        set_filter(text_chunk("ABCDEFGHIJKLMNOP", 0), text_chunk("ABCDEFGHIJKLMNOP", 8),
                   5'd31, 8'd15, 16'hFFFF);
        set_traffic(0, READY_ALWAYS);
        send_text("p");
        wait_for_verdicts();
        set_filter(text_chunk("ABCDEFGHIJKLMNOP", 0), 64'd0, 5'd0, 8'd1, 16'hFFFF);
        send_text("");
        send_text("q");
        wait_for_verdicts();
    endtask

    task automatic test_match_limit();
        int k;
        set_filter(text_chunk("Kite", 0), 64'd0, 5'd4, 8'd1, match_total + 16'd2);
        set_traffic(2, READY_RANDOM);
        for (k = 0; k < 4; k++) begin
            send_text("kIt");
        end
        wait_for_verdicts();
        set_filter(text_chunk("Kite", 0), 64'd0, 5'd4, 8'd1, 16'd0);
        send_text("kite!");
        send_text("kit");
        wait_for_verdicts();
    endtask

    // Words long enough to saturate the length counter and the row entries.
    task automatic test_long_words();
        int k;
        set_filter(text_chunk("abcdefghijklmnop", 0), text_chunk("abcdefghijklmnop", 8),
                   5'd16, 8'd255, 16'hFFFF);
        set_traffic(0, READY_PATTERN);
        word_buf.delete();
        for (k = 0; k < 300; k++) begin
            word_buf.insert(word_buf.size(), 8'($urandom_range(0, 255)));
        end
        send_word_buf();
        wait_for_verdicts();
        set_filter(text_chunk("abcdefghijklmnop", 0), text_chunk("abcdefghijklmnop", 8),
                   5'd16, 8'd254, 16'hFFFF);
        word_buf.delete();
        for (k = 0; k < 258; k++) begin
            word_buf.insert(word_buf.size(), random_letter());
        end
        send_word_buf();
        wait_for_verdicts();
    endtask

    task automatic send_mixed_words(input int count);
        int start;
        start = requests_sent;
        while (requests_sent - start < count) begin
            if ($urandom_range(0, 4) == 0) begin
                send_noise_word();
            end else begin
                mutate_query($urandom_range(0, 3));
                send_word_buf();
            end
        end
    endtask

    task automatic test_random_words(input int phases, input int per_phase);
        int p;
        for (p = 0; p < phases; p++) begin
            randomise_filter();
            case ($urandom_range(0, 2))
                0:       set_traffic(0, t_ready_mode'($urandom_range(0, 2)));
                1:       set_traffic(3, t_ready_mode'($urandom_range(0, 2)));
                default: set_traffic(8, t_ready_mode'($urandom_range(0, 2)));
            endcase
            send_mixed_words(per_phase);
            wait_for_verdicts();
        end
    endtask

    task automatic test_back_pressure();
        randomise_filter();
        set_traffic(0, READY_ALWAYS);
        hold_req = 1'b1;
        send_mixed_words(80);
        wait_for_verdicts();
        set_traffic(0, READY_RANDOM);
        send_mixed_words(30);
        wait_for_verdicts();
    endtask

    initial begin
        reset_filter();
        test_reset_state();
        test_case_folding();
        test_extreme_bytes();
        test_query_length_limits();
        test_match_limit();
        test_long_words();
        test_random_words(4, 55);
        test_back_pressure();
        $display("Sent %0d requests over %0d cycles; checked %0d words, %0d of them matches,",
                 requests_sent, cycle_count, verdicts_seen, matches_seen);
        $display("including case folding, saturating long words, match limits and hold-offs.");
        if (errors == 0 && expected_verdicts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
